// ----- hdl/ambs_pkg.sv -----
package ambs_pkg;

   localparam int MAP_SIZE        = 256;
   localparam int LAYERS          = 4;
   localparam int MAX_HALF_WINDOW = 63;

   localparam logic [7:0] FULL_ALPHA = 8'hff;
   localparam logic [7:0] NO_ALPHA   = 8'h00;

   localparam logic [11:0] INNER_RESET  = 12'd80;
   localparam logic [11:0] OUTER_RESET  = 12'd160;
   localparam logic [11:0] CUTOFF_RESET = 12'd160;
   localparam logic [15:0] GAIN_RESET   = 16'd13056;
   localparam logic [5:0]  HW_RESET     = 6'd10;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_INNER  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUTER  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CUTOFF = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HW     = 3'd4;

   localparam logic FUNC_STAMP = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   typedef struct packed {
      logic       func;
      logic [1:0] layer;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic       erase;
   } req_type;

   typedef struct packed {
      logic [7:0] read_alpha;
      logic       done_res;
   } rsp_type;

endpackage

// ----- hdl/ambs_ram.sv -----
module ambs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ----- hdl/alpha_map_brush_stamp.sv -----
// Read: an accepted beat passes ST_RREAD, ST_RDATA and ST_FIN, which registers the result beat.
// Stamp: each window pixel runs ST_PIX and ST_TEST, then is skipped, written at full strength,
// or on the ramp goes ST_SQRT (bit-serial square root), ST_MUL and ST_SAT before ST_WR.
// One item at a time; the single-port alpha RAM sets the per-pixel loop.
// Reset: synchronous; afterwards the RAM is swept to zero, one entry per
// cycle, over all 2**(LW+2*PW) entries (262144 at defaults), with req_stall held high.
module alpha_map_brush_stamp #(
   parameter int MAP_SIZE        = ambs_pkg::MAP_SIZE,
   parameter int LAYERS          = ambs_pkg::LAYERS,
   parameter int MAX_HALF_WINDOW = ambs_pkg::MAX_HALF_WINDOW
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ambs_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ambs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ambs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ambs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int PW    = $clog2(MAP_SIZE);
   localparam int LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   localparam int AW    = LW + 2 * PW;
   localparam int DEPTH = 2 ** AW;
   localparam int CW    = ((PW > 9) ? PW : 9) + 3;
   localparam int HWW   = $clog2(MAX_HALF_WINDOW + 1);
   localparam int D2W   = 2 * HWW + 1;
   localparam int SW    = D2W + 8;
   localparam int SQW   = SW + (SW % 2);
   localparam int CMPW  = (SQW > 24) ? SQW : 24;
   localparam int LENW  = (SQW > 12) ? SQW : 12;

   typedef enum logic [10:0] {
      ST_CLEAR = 11'b00000000001,
      ST_IDLE  = 11'b00000000010,
      ST_PIX   = 11'b00000000100,
      ST_TEST  = 11'b00000001000,
      ST_SQRT  = 11'b00000010000,
      ST_MUL   = 11'b00000100000,
      ST_SAT   = 11'b00001000000,
      ST_WR    = 11'b00010000000,
      ST_RREAD = 11'b00100000000,
      ST_RDATA = 11'b01000000000,
      ST_FIN   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [11:0] inner_ff, outer_ff, cutoff_ff;
   logic [15:0] gain_ff;
   logic [5:0]  hw_ff;

   logic [LW-1:0]        layer_ff, layer_in;
   logic                 erase_ff, erase_in;
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [CW-1:0] x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [D2W-1:0]       d2_ff, d2_in;
   logic [7:0]           cur_ff, cur_in, brush_ff, brush_in;
   logic [SQW-1:0]       sv_ff, sv_in, root_ff, root_in, sbit_ff, sbit_in;
   logic [27:0]          mul_ff, mul_in;
   logic [7:0]           alpha_ff, alpha_in;
   logic                 done_ff, done_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ambs_pkg::rsp_type    rsp_ff, rsp_in;

   logic [AW-1:0] ram_addr;
   logic          ram_we;
   logic [7:0]    ram_wdata, ram_rdata;

   logic signed [CW-1:0]   h, px, py, xs, xe, ys, ye, dx, dy;
   logic signed [2*CW-1:0] dxw, dyw, d2_full;
   logic [4:0]             layer_ext;
   logic                   layer_ok, in_map, win_empty, last_pix;
   logic [CMPW-1:0]        s_cmp, inner_sq, cut_sq;
   logic [SQW-1:0]         trial;
   logic [LENW-1:0]        len_w, outer_w;
   logic [11:0]            diff;
   logic [15:0]            mul_sh;

   ambs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff  <= ambs_pkg::INNER_RESET;
         outer_ff  <= ambs_pkg::OUTER_RESET;
         cutoff_ff <= ambs_pkg::CUTOFF_RESET;
         gain_ff   <= ambs_pkg::GAIN_RESET;
         hw_ff     <= ambs_pkg::HW_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ambs_pkg::REG_INNER:  inner_ff  <= csr_wdata[11:0];
            ambs_pkg::REG_OUTER:  outer_ff  <= csr_wdata[11:0];
            ambs_pkg::REG_CUTOFF: cutoff_ff <= csr_wdata[11:0];
            ambs_pkg::REG_GAIN:   gain_ff   <= csr_wdata;
            ambs_pkg::REG_HW:     hw_ff     <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      h = (32'(hw_ff) > MAX_HALF_WINDOW) ? CW'(MAX_HALF_WINDOW) : CW'(hw_ff);
      px = CW'(req_data.pos_x);
      py = CW'(req_data.pos_y);
      xs = (px - h < 0) ? '0 : px - h;
      ys = (py - h < 0) ? '0 : py - h;
      xe = (px + h > CW'(MAP_SIZE - 1)) ? CW'(MAP_SIZE - 1) : px + h;
      ye = (py + h > CW'(MAP_SIZE - 1)) ? CW'(MAP_SIZE - 1) : py + h;
      win_empty = (xs > xe) || (ys > ye);
      layer_ext = 5'(req_data.layer);
      layer_ok = (32'(req_data.layer) < LAYERS);
      in_map = (32'(req_data.pos_x) < MAP_SIZE) && (32'(req_data.pos_y) < MAP_SIZE);

      dx = x_ff - cx_ff;
      dy = y_ff - cy_ff;
      dxw = (2*CW)'(dx);
      dyw = (2*CW)'(dy);
      d2_full = dxw * dxw + dyw * dyw;

      s_cmp = CMPW'({d2_ff, 8'h00});
      inner_sq = CMPW'(inner_ff) * CMPW'(inner_ff);
      cut_sq = CMPW'(cutoff_ff) * CMPW'(cutoff_ff);
      trial = root_ff + sbit_ff;

      len_w = LENW'(root_ff);
      outer_w = LENW'(outer_ff);
      diff = (outer_w > len_w) ? 12'(outer_w - len_w) : 12'd0;
      mul_sh = mul_ff[27:12];
      last_pix = (x_ff == x1_ff) && (y_ff == y1_ff);
   end

   always_comb begin
      state_in = state_ff;
      layer_in = layer_ff;
      erase_in = erase_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      x_in = x_ff;
      y_in = y_ff;
      x0_in = x0_ff;
      x1_in = x1_ff;
      y1_in = y1_ff;
      clr_in = clr_ff;
      d2_in = d2_ff;
      cur_in = cur_ff;
      brush_in = brush_ff;
      sv_in = sv_ff;
      root_in = root_ff;
      sbit_in = sbit_ff;
      mul_in = mul_ff;
      alpha_in = alpha_ff;
      done_in = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      ram_we = 1'b0;
      ram_wdata = ambs_pkg::NO_ALPHA;
      ram_addr = {layer_ff, y_ff[PW-1:0], x_ff[PW-1:0]};

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               layer_in = layer_ext[LW-1:0];
               erase_in = req_data.erase;
               cx_in = px;
               cy_in = py;
               x_in = (req_data.func == ambs_pkg::FUNC_READ) ? px : xs;
               y_in = (req_data.func == ambs_pkg::FUNC_READ) ? py : ys;
               x0_in = xs;
               x1_in = xe;
               y1_in = ye;
               alpha_in = ambs_pkg::NO_ALPHA;
               done_in = layer_ok;
               if (!layer_ok) begin
                  state_in = ST_FIN;
               end else if (req_data.func == ambs_pkg::FUNC_READ) begin
                  done_in = in_map;
                  state_in = in_map ? ST_RREAD : ST_FIN;
               end else begin
                  state_in = win_empty ? ST_FIN : ST_PIX;
               end
            end
         end
         ST_PIX: begin
            d2_in = d2_full[D2W-1:0];
            state_in = ST_TEST;
         end
         ST_TEST: begin
            cur_in = ram_rdata;
            sv_in = SQW'({d2_ff, 8'h00});
            root_in = '0;
            sbit_in = SQW'(1) << (SQW - 2);
            if (s_cmp < inner_sq) begin
               brush_in = ambs_pkg::FULL_ALPHA;
               state_in = ST_WR;
            end else if (s_cmp >= cut_sq) begin
               if (last_pix) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_PIX;
                  if (x_ff == x1_ff) begin
                     x_in = x0_ff;
                     y_in = y_ff + 1'b1;
                  end else begin
                     x_in = x_ff + 1'b1;
                  end
               end
            end else begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sv_ff >= trial) begin
               sv_in = sv_ff - trial;
               root_in = (root_ff >> 1) + sbit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            if (sbit_ff[0]) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_in = 28'(diff) * 28'(gain_ff);
            state_in = ST_SAT;
         end
         ST_SAT: begin
            brush_in = (mul_sh > 16'(ambs_pkg::FULL_ALPHA)) ? ambs_pkg::FULL_ALPHA
                                                             : mul_sh[7:0];
            state_in = ST_WR;
         end
         ST_WR: begin
            ram_we = 1'b1;
            if (erase_ff) begin
               ram_wdata = (cur_ff > brush_ff) ? cur_ff - brush_ff : ambs_pkg::NO_ALPHA;
            end else begin
               ram_wdata = (cur_ff < brush_ff) ? brush_ff : cur_ff;
            end
            if (last_pix) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_PIX;
               if (x_ff == x1_ff) begin
                  x_in = x0_ff;
                  y_in = y_ff + 1'b1;
               end else begin
                  x_in = x_ff + 1'b1;
               end
            end
         end
         ST_RREAD: begin
            state_in = ST_RDATA;
         end
         ST_RDATA: begin
            alpha_in = ram_rdata;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.read_alpha = alpha_ff;
               rsp_in.done_res = done_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      layer_ff <= layer_in;
      erase_ff <= erase_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      x_ff <= x_in;
      y_ff <= y_in;
      x0_ff <= x0_in;
      x1_ff <= x1_in;
      y1_ff <= y1_in;
      d2_ff <= d2_in;
      cur_ff <= cur_in;
      brush_ff <= brush_in;
      sv_ff <= sv_in;
      root_ff <= root_in;
      sbit_ff <= sbit_in;
      mul_ff <= mul_in;
      alpha_ff <= alpha_in;
      done_ff <= done_in;
      rsp_ff <= rsp_in;
   end

   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request taken before memory sweep");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FIN))
      else $error("response beat not from finish state");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_WR || state_ff == ST_CLEAR))
      else $error("alpha memory written outside write or sweep");

endmodule

// ----- verif/alpha_map_brush_stamp_checker.sv -----
`timescale 1ns / 1ps

module alpha_map_brush_stamp_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  ambs_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  ambs_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [ambs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ambs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              pending,
   output int                              fail_count
);

   localparam int MAP_WORDS = ambs_pkg::LAYERS * ambs_pkg::MAP_SIZE * ambs_pkg::MAP_SIZE;

   logic [7:0]        alpha_mem [0:MAP_WORDS-1];
   logic [11:0]       inner_r, outer_r, cutoff_r;
   logic [15:0]       gain_r;
   logic [5:0]        half_w;
   ambs_pkg::rsp_type result_q[$];

   function automatic int unsigned floor_root(int unsigned v);
      int unsigned root;
      int unsigned bitv;
      root = 0;
      bitv = 32'h4000_0000;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v    = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   task automatic paint(input int lyr, input int cx, input int cy, input logic erase);
      int h, x0, x1, y0, y1, dx, dy, idx;
      int unsigned s, len, diff, v, b, cur;
      h  = (half_w > ambs_pkg::MAX_HALF_WINDOW) ? ambs_pkg::MAX_HALF_WINDOW : half_w;
      x0 = (cx - h < 0) ? 0 : cx - h;
      y0 = (cy - h < 0) ? 0 : cy - h;
      x1 = (cx + h > ambs_pkg::MAP_SIZE - 1) ? ambs_pkg::MAP_SIZE - 1 : cx + h;
      y1 = (cy + h > ambs_pkg::MAP_SIZE - 1) ? ambs_pkg::MAP_SIZE - 1 : cy + h;
      for (int y = y0; y <= y1; y++) begin
         for (int x = x0; x <= x1; x++) begin
            dx = x - cx;
            dy = y - cy;
            s  = (dx * dx + dy * dy) * 256;
            if (s < inner_r * inner_r) begin
               b = ambs_pkg::FULL_ALPHA;
            end else if (s >= cutoff_r * cutoff_r) begin
               continue;
            end else begin
               len  = floor_root(s);
               diff = (outer_r > len) ? outer_r - len : 0;
               v    = (diff * gain_r) >> 12;
               b    = (v > ambs_pkg::FULL_ALPHA) ? ambs_pkg::FULL_ALPHA : v;
            end
            idx = (lyr * ambs_pkg::MAP_SIZE + y) * ambs_pkg::MAP_SIZE + x;
            cur = alpha_mem[idx];
            if (erase) cur = (cur > b) ? cur - b : ambs_pkg::NO_ALPHA;
            else       cur = (cur < b) ? b : cur;
            alpha_mem[idx] = cur[7:0];
         end
      end
   endtask

   initial begin
      for (int i = 0; i < MAP_WORDS; i++) alpha_mem[i] = ambs_pkg::NO_ALPHA;
   end

   always @(posedge clock) begin
      ambs_pkg::rsp_type want, got;
      if (reset) begin
         inner_r    = ambs_pkg::INNER_RESET;
         outer_r    = ambs_pkg::OUTER_RESET;
         cutoff_r   = ambs_pkg::CUTOFF_RESET;
         gain_r     = ambs_pkg::GAIN_RESET;
         half_w     = ambs_pkg::HW_RESET;
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ambs_pkg::REG_INNER:  inner_r  = csr_wdata[11:0];
               ambs_pkg::REG_OUTER:  outer_r  = csr_wdata[11:0];
               ambs_pkg::REG_CUTOFF: cutoff_r = csr_wdata[11:0];
               ambs_pkg::REG_GAIN:   gain_r   = csr_wdata;
               ambs_pkg::REG_HW:     half_w   = csr_wdata[5:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want = '0;
            if (req_data.layer < ambs_pkg::LAYERS) begin
               if (req_data.func == ambs_pkg::FUNC_STAMP) begin
                  paint(req_data.layer, req_data.pos_x, req_data.pos_y, req_data.erase);
                  want.done_res = 1'b1;
               end else begin
                  want.read_alpha = alpha_mem[(req_data.layer * ambs_pkg::MAP_SIZE
                                               + req_data.pos_y) * ambs_pkg::MAP_SIZE
                                              + req_data.pos_x];
                  want.done_res = 1'b1;
               end
            end
            result_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (result_q.size() == 0) begin
               $error("result beat with nothing expected: alpha %0d done %0d",
                      got.read_alpha, got.done_res);
               fail_count++;
            end else begin
               want = result_q.pop_front();
               if (got.read_alpha !== want.read_alpha) begin
                  $error("read_alpha: expected %0d, got %0d", want.read_alpha, got.read_alpha);
                  fail_count++;
               end
               if (got.done_res !== want.done_res) begin
                  $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
                  fail_count++;
               end
            end
         end
      end
      pending = result_q.size();
   end

endmodule

// ----- verif/alpha_map_brush_stamp_tb.sv -----
`timescale 1ns / 1ps

module alpha_map_brush_stamp_tb;

   localparam int CYCLE_LIMIT = 30_000_000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   ambs_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   ambs_pkg::rsp_type               rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [ambs_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ambs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   int                              pending;
   int                              fail_count;

   int sent_items = 0;
   int stamp_count = 0;
   int read_count = 0;
   int burst_left = 0;
   int last_x = 128, last_y = 128, last_layer = 0;
   int cycle_count = 0;

   always #5 clock = ~clock;

   alpha_map_brush_stamp u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   alpha_map_brush_stamp_checker u_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending(pending), .fail_count(fail_count)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("alpha_map_brush_stamp: mismatch");
         $finish;
      end
   end

   // receiver stall: pattern mode is redrawn whenever mode_cnt wraps, plus one long hold-off
   int stall_mode = 0, mode_cnt = 0, hold_cnt = 0;
   bit held = 0;
   always @(posedge clock) begin
      if (!held && sent_items >= 200) begin
         held     = 1;
         hold_cnt = 600;
      end
      if (++mode_cnt >= 64) begin
         mode_cnt   = 0;
         stall_mode = $urandom_range(0, 3);
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= $urandom_range(0, 1);
            2: rsp_stall <= ($urandom_range(0, 9) < 8);
            default: rsp_stall <= mode_cnt[2];
         endcase
      end
   end

   task automatic wait_idle();
      do @(negedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ambs_pkg::CSR_IDX_W-1:0] idx, input int unsigned val);
      bit ok;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[ambs_pkg::CSR_DATA_W-1:0];
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
   endtask

   task automatic set_brush(input int inner, input int outer, input int cutoff,
                            input int gain, input int hw);
      req_valid <= 1'b0;
      wait_idle();
      write_reg(ambs_pkg::REG_INNER, inner);
      write_reg(ambs_pkg::REG_OUTER, outer);
      write_reg(ambs_pkg::REG_CUTOFF, cutoff);
      write_reg(ambs_pkg::REG_GAIN, gain);
      write_reg(ambs_pkg::REG_HW, hw);
      csr_valid <= 1'b0;
   endtask

   task automatic send(input logic func, input int lyr, input int x, input int y,
                       input logic erase);
      bit ok;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_data.func  <= func;
      req_data.layer <= lyr[1:0];
      req_data.pos_x <= x[7:0];
      req_data.pos_y <= y[7:0];
      req_data.erase <= erase;
      do begin
         @(negedge clock);
         ok = !req_stall;
         @(posedge clock);
      end while (!ok);
      sent_items++;
      if (func == ambs_pkg::FUNC_STAMP) begin
         stamp_count++;
         last_x = x; last_y = y; last_layer = lyr;
      end else begin
         read_count++;
      end
   endtask

   task automatic random_beat();
      if ($urandom_range(0, 1) == 0) begin
         send(ambs_pkg::FUNC_STAMP, $urandom_range(0, 3), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 9) < 3);
      end else if ($urandom_range(0, 4) != 0) begin
         send(ambs_pkg::FUNC_READ,
              ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : last_layer,
              (last_x + $urandom_range(0, 12) - 6) & 255,
              (last_y + $urandom_range(0, 12) - 6) & 255, $urandom_range(0, 1));
      end else begin
         send(ambs_pkg::FUNC_READ, $urandom_range(0, 3), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 1));
      end
   endtask

   initial begin
      int inner, outer;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset brush settings
      send(ambs_pkg::FUNC_READ,  3, 255, 255, 1'b0);
      send(ambs_pkg::FUNC_STAMP, 0, 128, 128, 1'b0);
      send(ambs_pkg::FUNC_READ,  0, 128, 128, 1'b0);
      send(ambs_pkg::FUNC_READ,  0, 135, 128, 1'b0);
      send(ambs_pkg::FUNC_READ,  0, 133, 133, 1'b0);
      send(ambs_pkg::FUNC_READ,  0, 138, 128, 1'b0);
      send(ambs_pkg::FUNC_STAMP, 0, 130, 128, 1'b1);
      send(ambs_pkg::FUNC_READ,  0, 128, 128, 1'b0);
      send(ambs_pkg::FUNC_READ,  0, 126, 128, 1'b0);
      send(ambs_pkg::FUNC_STAMP, 1, 0, 0, 1'b0);
      send(ambs_pkg::FUNC_STAMP, 2, 255, 255, 1'b0);
      send(ambs_pkg::FUNC_STAMP, 3, 0, 255, 1'b1);
      send(ambs_pkg::FUNC_STAMP, 3, 255, 0, 1'b0);
      send(ambs_pkg::FUNC_READ,  1, 0, 0, 1'b1);
      send(ambs_pkg::FUNC_READ,  2, 255, 255, 1'b0);
      send(ambs_pkg::FUNC_READ,  3, 255, 0, 1'b1);
      send(ambs_pkg::FUNC_READ,  3, 250, 4, 1'b0);
      send(ambs_pkg::FUNC_STAMP, 3, 255, 0, 1'b1);
      send(ambs_pkg::FUNC_READ,  3, 255, 0, 1'b0);
      send(ambs_pkg::FUNC_STAMP, 2, 40, 40, 1'b1);
      send(ambs_pkg::FUNC_READ,  2, 40, 40, 1'b0);

      for (int phase = 0; phase < 15; phase++) begin
         case (phase)
            0: set_brush(0, 0, 0, 0, 3);
            1: set_brush(4095, 4095, 4095, 65535, 2);
            2: set_brush(60, 200, 30, 9000, 4);
            3: begin
               set_brush(1000, 2000, 2000, 500, 63);
               write_reg(5, 16'hffff);
               write_reg(7, 0);
               csr_valid <= 1'b0;
               send(ambs_pkg::FUNC_STAMP, 1, 0, 0, 1'b0);
               send(ambs_pkg::FUNC_READ,  1, 63, 63, 1'b0);
               send(ambs_pkg::FUNC_STAMP, 1, 255, 255, 1'b1);
               send(ambs_pkg::FUNC_READ,  1, 200, 200, 1'b0);
            end
            4: set_brush(16, 40, 110, 65535, 5);
            5: set_brush(0, 4095, 100, 65535, 4);
            default: begin
               inner = $urandom_range(0, 90);
               outer = inner + $urandom_range(1, 120);
               set_brush(inner, outer, $urandom_range(0, 200),
                         ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                     : 255 * 4096 / (outer - inner),
                         $urandom_range(0, 4));
            end
         endcase
         repeat (37) random_beat();
      end
      req_valid <= 1'b0;

      wait_idle();
      repeat (200) @(posedge clock);
      $display("covered %0d beats: %0d stamps, %0d reads over 15 brush settings",
               sent_items, stamp_count, read_count);
      $display("including zero, full-scale, inverted-radius and widest-window brushes");
      if (fail_count == 0) begin
         $display("alpha_map_brush_stamp: match");
      end else begin
         $display("alpha_map_brush_stamp: mismatch");
      end
      $finish;
   end

endmodule
